FILE: src/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the motor feedback decoder.
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int ID_W    = 11;
    localparam int DATA_W  = 64;
    localparam int CFG_W   = 11;
    localparam int SLOT_W  = 4;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int TURN_W  = 32;
    localparam int SHIFT_W = 13;   // 8192 counts per turn
    localparam int TOTAL_W = 46;

    localparam logic signed [WORD_W-1:0] HALF_TURN = 16'sd4096;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_SLOT_ENABLE  = 1'b0,
        REG_ERROR_REPORT = 1'b1
    } t_cfg_reg;

    // per-slot state word kept in the state memory
    typedef struct packed {
        logic [WORD_W-1:0] prev_angle;
        logic [TURN_W-1:0] turns;
        logic [BYTE_W-1:0] prev_error;
    } t_slot_state;

endpackage

FILE: src/mfd_state_mem.sv
// ----------------------------------------------------------------------------
// mfd_state_mem
// Per-slot state memory, registered read, one write port.
// Entries read as zero until first written; a write in the same cycle
// as a read of the same entry is forwarded to the read data.
// ----------------------------------------------------------------------------
module mfd_state_mem #(
    parameter int DEPTH  = 11,
    parameter int ADDR_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  mfd_pkg::t_slot_state i_wr_data,
    output mfd_pkg::t_slot_state o_rd_data
);

    mfd_pkg::t_slot_state r_mem [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    mfd_pkg::t_slot_state r_q;
    mfd_pkg::t_slot_state r_fwd;
    logic                 r_fwd_hit;
    logic                 r_live;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q   <= r_mem[i_rd_addr];
            r_fwd <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fwd_hit <= 1'b0;
            r_live    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
                r_live    <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd : (r_live ? r_q : '0);

endmodule

FILE: src/mfd_turn_update.sv
// ----------------------------------------------------------------------------
// mfd_turn_update
// Turn counter step, total angle and error-change detect for one frame.
// ----------------------------------------------------------------------------
module mfd_turn_update (
    input  mfd_pkg::t_slot_state                 i_state,
    input  logic        [mfd_pkg::WORD_W-1:0]    i_angle,
    input  logic        [mfd_pkg::BYTE_W-1:0]    i_error,
    input  logic                                 i_report,
    output mfd_pkg::t_slot_state                 o_state,
    output logic signed [mfd_pkg::TOTAL_W-1:0]   o_total,
    output logic                                 o_changed
);

    logic signed [mfd_pkg::WORD_W-1:0] w_diff;
    logic        [mfd_pkg::TURN_W-1:0] w_turns;

    // angle delta wraps in 16 bits
    assign w_diff = $signed(i_angle - i_state.prev_angle);

    always_comb begin
        w_turns = i_state.turns;
        if (w_diff < -mfd_pkg::HALF_TURN) begin
            w_turns = i_state.turns + 32'd1;
        end else if (w_diff > mfd_pkg::HALF_TURN) begin
            w_turns = i_state.turns - 32'd1;
        end
    end

    assign o_state.prev_angle = i_angle;
    assign o_state.turns      = w_turns;
    assign o_state.prev_error = i_error;

    assign o_total = $signed({w_turns[mfd_pkg::TURN_W-1], w_turns, {mfd_pkg::SHIFT_W{1'b0}}})
                   + $signed({{(mfd_pkg::TOTAL_W-mfd_pkg::WORD_W){i_angle[mfd_pkg::WORD_W-1]}},
                              i_angle});

    assign o_changed = i_report && (i_error != i_state.prev_error);

endmodule

FILE: src/motor_feedback_decoder.sv
// ----------------------------------------------------------------------------
// motor_feedback_decoder
// Decodes motor feedback frames and unwraps the encoder angle per slot.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one frame: id and 8 bytes.
// Output channel (o_out_valid / i_out_ready) carries one result per frame;
// rejected frames (id outside the slot window or slot disabled) still give a
// result with o_accepted low and all other fields zero.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0: slot enable, 1: error report mask) at the clock edge; write while idle.
// Pipeline: a transferred frame is captured into stage 1 together with the
// state memory read, then updated into the output register when stage 1
// advances. Throughput: one frame per cycle while the receiver takes results;
// the per-slot read-modify-write of the state memory is forwarded so
// back-to-back frames to one slot are exact.
// Receiver stall: the output register holds, the update stage holds, and
// o_in_ready drops once both are full; nothing is lost.
// Reset (synchronous, active low) clears config, pipeline valids and the
// per-entry valid bits of the state memory, so all slots read as zero at once.
// ----------------------------------------------------------------------------
module motor_feedback_decoder #(
    parameter int ID_BASE   = 513,
    parameter int NUM_SLOTS = 11
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic        [0:0]                    i_cfg_index,
    input  logic        [mfd_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic        [mfd_pkg::ID_W-1:0]      i_frame_id,
    input  logic        [mfd_pkg::DATA_W-1:0]    i_frame_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_accepted,
    output logic        [mfd_pkg::SLOT_W-1:0]    o_slot_index,
    output logic signed [mfd_pkg::WORD_W-1:0]    o_angle,
    output logic signed [mfd_pkg::WORD_W-1:0]    o_velocity,
    output logic signed [mfd_pkg::WORD_W-1:0]    o_current,
    output logic        [mfd_pkg::BYTE_W-1:0]    o_temperature,
    output logic        [mfd_pkg::BYTE_W-1:0]    o_error_code,
    output logic signed [mfd_pkg::TURN_W-1:0]    o_turn_count,
    output logic signed [mfd_pkg::TOTAL_W-1:0]   o_total_angle,
    output logic                                 o_error_changed
);

    localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int OFF_W  = mfd_pkg::ID_W + 1;

    // configuration
    logic [mfd_pkg::CFG_W-1:0] r_slot_enable;
    logic [mfd_pkg::CFG_W-1:0] r_error_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_enable  <= '0;
            r_error_report <= '0;
        end else if (i_cfg_we) begin
            case (mfd_pkg::t_cfg_reg'(i_cfg_index))
                mfd_pkg::REG_SLOT_ENABLE:  r_slot_enable  <= i_cfg_wdata;
                mfd_pkg::REG_ERROR_REPORT: r_error_report <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 0: window and enable check, memory read issue
    logic [OFF_W-1:0]          w_off;
    logic [mfd_pkg::SLOT_W-1:0] w_slot;
    logic [15:0]               w_en_vec;
    logic [15:0]               w_rep_vec;
    logic                      w_hit;
    logic                      w_in_xfer;

    assign w_off     = {1'b0, i_frame_id} - OFF_W'(ID_BASE);
    assign w_slot    = w_off[mfd_pkg::SLOT_W-1:0];
    assign w_en_vec  = 16'(r_slot_enable);
    assign w_rep_vec = 16'(r_error_report);
    assign w_hit     = !w_off[OFF_W-1] && (w_off < OFF_W'(NUM_SLOTS)) && w_en_vec[w_slot];
    assign w_in_xfer = i_in_valid && o_in_ready;

    // stage 1: update
    logic                        r_s1_valid;
    logic                        r_s1_hit;
    logic [mfd_pkg::SLOT_W-1:0]  r_s1_slot;
    logic                        r_s1_report;
    logic [mfd_pkg::DATA_W-1:0]  r_s1_data;
    logic                        w_s1_adv;
    logic                        w_wr_en;
    mfd_pkg::t_slot_state        w_rd_state;
    mfd_pkg::t_slot_state        w_new_state;
    logic signed [mfd_pkg::TOTAL_W-1:0] w_total;
    logic                        w_changed;

    assign w_s1_adv   = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_wr_en    = w_s1_adv && r_s1_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_hit    <= w_hit;
            r_s1_slot   <= w_slot;
            r_s1_report <= w_rep_vec[w_slot];
            r_s1_data   <= i_frame_data;
        end
    end

    mfd_state_mem #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_xfer),
        .i_rd_addr (w_slot[ADDR_W-1:0]),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_slot[ADDR_W-1:0]),
        .i_wr_data (w_new_state),
        .o_rd_data (w_rd_state)
    );

    mfd_turn_update u_turn_update (
        .i_state   (w_rd_state),
        .i_angle   (r_s1_data[63:48]),
        .i_error   (r_s1_data[7:0]),
        .i_report  (r_s1_report),
        .o_state   (w_new_state),
        .o_total   (w_total),
        .o_changed (w_changed)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            if (r_s1_hit) begin
                o_accepted      <= 1'b1;
                o_slot_index    <= r_s1_slot;
                o_angle         <= $signed(r_s1_data[63:48]);
                o_velocity      <= $signed(r_s1_data[47:32]);
                o_current       <= $signed(r_s1_data[31:16]);
                o_temperature   <= r_s1_data[15:8];
                o_error_code    <= r_s1_data[7:0];
                o_turn_count    <= $signed(w_new_state.turns);
                o_total_angle   <= w_total;
                o_error_changed <= w_changed;
            end else begin
                o_accepted      <= 1'b0;
                o_slot_index    <= '0;
                o_angle         <= '0;
                o_velocity      <= '0;
                o_current       <= '0;
                o_temperature   <= '0;
                o_error_code    <= '0;
                o_turn_count    <= '0;
                o_total_angle   <= '0;
                o_error_changed <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // full pipeline with a stalled receiver must back-pressure the sender
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input ready while pipeline is full and stalled");

    // low bits of the total are the raw angle bits
    a_total_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_total_angle[12:0] == o_angle[12:0])
        else $error("total angle low bits disagree with angle");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_slot_index < mfd_pkg::SLOT_W'(NUM_SLOTS))
        else $error("accepted result with slot out of range");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> o_turn_count == 0 && o_total_angle == 0
            && !o_error_changed)
        else $error("rejected result carries nonzero fields");
`endif

endmodule
